@@ design/ptw_pkg.sv @@
// Package with shared types, constants and helper functions of the page-table walker.
`default_nettype none
package ptw_pkg;
	localparam int PHYS_ADDR_BITS_DEF = 16;
	localparam int MAX_LEVELS_DEF     = 4;
	localparam int VADDR_BITS_DEF     = 48;
	localparam int DATA_W             = 64;
	localparam int PA_OUT_W           = 16;
	localparam int CFG_W              = 16;
	localparam int CFG_IDX_W          = 3;
	localparam int SHIFT_W            = 6;
	localparam int IDX_W              = 9;
	localparam int FRAME_LSB          = 12;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAGE_LOG2   = 3'd0,
		REG_LEVELS      = 3'd1,
		REG_BITS0       = 3'd2,
		REG_BITS1       = 3'd3,
		REG_BITS2       = 3'd4,
		REG_BITS3       = 3'd5,
		REG_FIRST_FRAME = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NOT_MAPPED  = 3'd1,
		ST_NOT_PRESENT = 3'd2,
		ST_WRITE_DENY  = 3'd3,
		ST_BAD_ADDR    = 3'd4,
		ST_NO_MEMORY   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_ENTRY,
		S_FINAL,
		S_LOAD,
		S_DONE
	} state_t;

	// Page size exponent clamped into 12..15.
	function automatic logic [3:0] sat_page(input logic [3:0] v);
		logic [3:0] r;
		r = (v < 4'd12) ? 4'd12 : v;
		return r;
	endfunction

	// Index width clamped into 1..9.
	function automatic logic [3:0] sat_bits(input logic [3:0] v);
		logic [3:0] r;
		if (v < 4'd1) r = 4'd1;
		else if (v > 4'd9) r = 4'd9;
		else r = v;
		return r;
	endfunction
endpackage
`default_nettype wire

@@ design/page_table_walker_with_demand_alloc.sv @@
// Top level of the page-table walker with demand allocation.
//
// Usage: a load or store transaction (func, vaddr, store_value) enters on the
// in_valid/in_ready channel; one result transaction (load_data, phys_addr,
// status) leaves on the out_valid/out_ready channel for each input.
// The walker works on one transaction at a time. All tables and data words
// live in one single-port RAM of 2^PHYS_ADDR_BITS words, each with a valid bit.
// Each level takes an address step (S_LOOK) and an entry check (S_ENTRY); the
// data access follows in S_FINAL, and for a load in S_LOAD as well, plus the
// accept in S_IDLE and the hand-off in S_DONE. A failing walk goes to S_DONE
// as soon as the fault is found. After reset the valid bits are cleared by a
// pass over all 2^PHYS_ADDR_BITS words (65536 at the default), during which
// in_ready stays low; configuration writes are taken at any time. A finished
// result waits in the output register; while the receiver stalls, the walker
// holds its next result and takes no new input.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data.
`default_nettype none
module page_table_walker_with_demand_alloc
	import ptw_pkg::*;
#(
	parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF,
	parameter int MAX_LEVELS     = MAX_LEVELS_DEF,
	parameter int VADDR_BITS     = VADDR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  func,
	input  wire logic [VADDR_BITS-1:0] vaddr,
	input  wire logic [DATA_W-1:0]     store_value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [DATA_W-1:0]     load_data,
	output logic      [PA_OUT_W-1:0]   phys_addr,
	output logic      [2:0]            status,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);
	localparam int P     = PHYS_ADDR_BITS;
	localparam int NF_W  = (P + 1 > 17) ? P + 1 : 17;
	localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int MEM_W = DATA_W + 1;

	// Configuration registers and pointers.
	logic [3:0]        page_log2_q, levels_raw_q;
	logic [3:0]        bits_q [4];
	logic [CFG_W-1:0]  root_q;
	logic [NF_W-1:0]   nf_q;
	logic [3:0]        pl;
	logic [2:0]        nl;

	// Walk context.
	state_t            state_q, state_d;
	logic              func_q;
	logic [VADDR_BITS-1:0] va_q;
	logic [DATA_W-1:0] sv_q;
	logic [SHIFT_W-1:0] sh_q [MAX_LEVELS];
	logic [LVL_W-1:0]  lvl_q;
	logic [P-1:0]      curr_q, ea_q, clr_q;
	logic              curr_big_q;
	logic [DATA_W-1:0] res_data_q;
	logic [P-1:0]      res_pa_q;
	status_t           res_st_q;
	logic [DATA_W-1:0] out_data_q;
	logic [PA_OUT_W-1:0] out_pa_q;
	logic [2:0]        out_st_q;
	logic              out_valid_q;

	// RAM port.
	logic              mem_we;
	logic [P-1:0]      mem_addr;
	logic [MEM_W-1:0]  mem_wdata, mem_rdata;

	ptw_ram #(.WIDTH(MEM_W), .DEPTH(2 ** P)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign pl = sat_page(page_log2_q);
	always_comb begin
		if (levels_raw_q < 4'd1) nl = 3'd1;
		else if (levels_raw_q > 4'(MAX_LEVELS)) nl = 3'(MAX_LEVELS);
		else nl = levels_raw_q[2:0];
	end

	// Per-level shift amounts: the last level sits just above the page offset,
	// and each level above it adds the index widths of the levels below.
	logic [SHIFT_W-1:0] sh_lvl [MAX_LEVELS];
	always_comb begin
		logic [SHIFT_W-1:0] acc;
		acc = SHIFT_W'(pl);
		for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
			sh_lvl[i] = acc;
			if (i < int'(nl)) begin
				acc = acc + SHIFT_W'(sat_bits(bits_q[i & 3]));
			end
		end
	end

	// Index of the current level and the entry address.
	logic [VADDR_BITS-1:0] va_sh;
	logic [IDX_W-1:0]      idx, idx_mask;
	logic [3:0]            lvl_bits;
	logic [P:0]            ea_sum;
	assign va_sh    = va_q >> sh_q[lvl_q];
	assign lvl_bits = sat_bits(bits_q[2'(lvl_q)]);
	assign idx_mask = IDX_W'((10'd1 << lvl_bits) - 10'd1);
	assign idx      = va_sh[IDX_W-1:0] & idx_mask;
	assign ea_sum   = {1'b0, curr_q} + (P+1)'({idx, 3'b000});

	// Entry decode and allocation.
	logic              ent_valid;
	logic [DATA_W-1:0] ent_word, alloc_word;
	logic [NF_W:0]     nf_next, lim_ext;
	logic [NF_W-1:0]   page_sz;
	logic              last_lvl;
	assign ent_valid  = mem_rdata[DATA_W];
	assign page_sz    = NF_W'(1) << pl;
	assign nf_next    = {1'b0, nf_q} + {1'b0, page_sz};
	assign lim_ext    = (NF_W+1)'(1) << P;
	assign alloc_word = DATA_W'({nf_q[NF_W-1:FRAME_LSB], {FRAME_LSB{1'b0}}}) | DATA_W'(7);
	assign ent_word   = ent_valid ? mem_rdata[DATA_W-1:0] : alloc_word;
	assign last_lvl   = (32'(lvl_q) == 32'(nl) - 32'd1);

	// Final physical address.
	logic [15:0] off;
	logic [P:0]  pa_sum;
	assign off    = 16'(va_q[15:0] & ((16'd1 << pl) - 16'd1));
	assign pa_sum = {1'b0, curr_q} + (P+1)'(off);

	logic [31:0] root_ext;
	assign root_ext = 32'(root_q);

	// Next state, RAM control.
	logic   ld_ctx, ld_res, alloc, set_curr, lvl_inc, clr_inc, out_load;
	status_t st_d;
	logic [DATA_W-1:0] data_d;
	logic [P-1:0] pa_d, curr_d;
	logic curr_big_d;
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_addr  = ea_q;
		mem_wdata = '0;
		ld_ctx    = 1'b0;
		ld_res    = 1'b0;
		alloc     = 1'b0;
		set_curr  = 1'b0;
		lvl_inc   = 1'b0;
		clr_inc   = 1'b0;
		out_load  = 1'b0;
		st_d      = ST_OK;
		data_d    = '0;
		pa_d      = '0;
		curr_d    = {ent_word[P-1:FRAME_LSB], {FRAME_LSB{1'b0}}};
		curr_big_d = |ent_word[DATA_W-1:P];
		in_ready  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				clr_inc  = 1'b1;
				if (&clr_q) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ld_ctx  = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				mem_addr = ea_sum[P-1:0];
				if (curr_big_q || ea_sum[P]) begin
					ld_res  = 1'b1;
					st_d    = ST_NO_MEMORY;
					state_d = S_DONE;
				end else begin
					state_d = S_ENTRY;
				end
			end
			S_ENTRY: begin
				priority if (!ent_valid && last_lvl && !func_q) begin
					ld_res = 1'b1;
					st_d   = ST_NOT_MAPPED;
					state_d = S_DONE;
				end else if (!ent_valid && nf_next > lim_ext) begin
					ld_res = 1'b1;
					st_d   = ST_NO_MEMORY;
					state_d = S_DONE;
				end else begin
					if (!ent_valid) begin
						mem_we    = 1'b1;
						mem_wdata = {1'b1, alloc_word};
						alloc     = 1'b1;
					end
					priority if (!ent_word[0]) begin
						ld_res = 1'b1;
						st_d   = ST_NOT_PRESENT;
						state_d = S_DONE;
					end else if (!ent_word[1] && func_q) begin
						ld_res = 1'b1;
						st_d   = ST_WRITE_DENY;
						state_d = S_DONE;
					end else begin
						set_curr = 1'b1;
						if (last_lvl) begin
							state_d = S_FINAL;
						end else begin
							lvl_inc = 1'b1;
							state_d = S_LOOK;
						end
					end
				end
			end
			S_FINAL: begin
				mem_addr = pa_sum[P-1:0];
				if (curr_big_q || pa_sum[P]) begin
					ld_res  = 1'b1;
					st_d    = ST_NO_MEMORY;
					state_d = S_DONE;
				end else if (func_q) begin
					mem_we    = 1'b1;
					mem_wdata = {1'b1, sv_q};
					ld_res    = 1'b1;
					pa_d      = pa_sum[P-1:0];
					state_d   = S_DONE;
				end else begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				ld_res = 1'b1;
				if (ent_valid) begin
					data_d = mem_rdata[DATA_W-1:0];
					pa_d   = ea_q;
				end else begin
					st_d = ST_BAD_ADDR;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers, pointers and control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_log2_q   <= 4'd12;
			levels_raw_q  <= 4'd2;
			bits_q[0]     <= 4'd4;
			bits_q[1]     <= 4'd4;
			bits_q[2]     <= 4'd4;
			bits_q[3]     <= 4'd4;
			root_q        <= 16'd4096;
			nf_q          <= NF_W'(8192);
			clr_q         <= '0;
			lvl_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PAGE_LOG2:   page_log2_q  <= cfg_data[3:0];
					REG_LEVELS:      levels_raw_q <= {1'b0, cfg_data[2:0]};
					REG_BITS0:       bits_q[0]    <= cfg_data[3:0];
					REG_BITS1:       bits_q[1]    <= cfg_data[3:0];
					REG_BITS2:       bits_q[2]    <= cfg_data[3:0];
					REG_BITS3:       bits_q[3]    <= cfg_data[3:0];
					REG_FIRST_FRAME: begin
						root_q        <= cfg_data;
						nf_q          <= NF_W'(cfg_data) + page_sz;
					end
					default: ;
				endcase
			end else if (alloc) begin
				nf_q <= nf_next[NF_W-1:0];
			end
			if (clr_inc) clr_q <= clr_q + P'(1);
			if (ld_ctx) lvl_q <= '0;
			else if (lvl_inc) lvl_q <= lvl_q + LVL_W'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Walk context and result payload.
	always_ff @(posedge clk) begin
		if (ld_ctx) begin
			func_q     <= func;
			va_q       <= vaddr;
			sv_q       <= store_value;
			sh_q       <= sh_lvl;
			curr_q     <= root_ext[P-1:0];
			curr_big_q <= (root_ext >= (32'd1 << P));
		end else if (set_curr) begin
			curr_q     <= curr_d;
			curr_big_q <= curr_big_d;
		end
		if (state_q == S_LOOK) ea_q <= ea_sum[P-1:0];
		else if (state_q == S_FINAL) ea_q <= pa_sum[P-1:0];
		if (ld_res) begin
			res_st_q   <= st_d;
			res_data_q <= data_d;
			res_pa_q   <= pa_d;
		end
		if (out_load) begin
			out_st_q   <= res_st_q;
			out_data_q <= res_data_q;
			out_pa_q   <= PA_OUT_W'(res_pa_q);
		end
	end

	assign out_valid = out_valid_q;
	assign load_data = out_data_q;
	assign phys_addr = out_pa_q;
	assign status    = out_st_q;

`ifndef ASSERT_OFF
	// No input is taken during the clearing pass or while a walk is running.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE)
		else $error("in_ready outside idle");

	// A failing result carries neither data nor an address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (load_data == '0 && phys_addr == '0))
		else $error("failing result with payload");

	// The RAM is never written while idle or handing off a result.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
		else $error("RAM write outside a walk");

	// Each accepted transaction leads to a walk step next cycle.
	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_LOOK)
		else $error("accept without walk");
`endif
endmodule
`default_nettype wire

@@ design/ptw_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module ptw_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Read before write (a write returns the old word); the read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire
